// ===== rtl/core/tce_pkg.sv =====
package tce_pkg;

   // Field widths and fixed-point anchors.
   localparam int COMP_W = 13;
   localparam int Q16_W = 17;
   localparam int PROD_W = 2 * Q16_W;
   localparam int ACC_W = 33;

   localparam logic [COMP_W-1:0] ONE_C = 13'd4096;
   localparam logic [COMP_W-1:0] STEP_C = 13'd205;
   localparam logic [COMP_W-1:0] RESET_RATIO_FLOOR = 13'd1152;

   // Adjustment loop bound.
   localparam int MAX_STEPS = 20;
   localparam int STEP_CNT_W = $clog2(MAX_STEPS + 1);

   // Luminance weights and contrast constants, all Q16.
   localparam logic [15:0] W_RED = 16'd13933;
   localparam logic [15:0] W_GREEN = 16'd46871;
   localparam logic [15:0] W_BLUE = 16'd4732;
   localparam logic [Q16_W-1:0] OFFSET_Q16 = 17'd3277;
   localparam logic [Q16_W-1:0] HALF_Q16 = 17'd32768;
   localparam logic [34:0] ROUND_Q16 = 35'd32768;

   // sRGB curve: the linear segment covers components up to the knee.
   localparam logic [COMP_W-1:0] LIN_KNEE = 13'd165;
   localparam int DIVIDEND_W = 27;
   localparam logic [DIVIDEND_W-1:0] LIN_SCALE = 27'd1600;
   localparam logic [DIVIDEND_W-1:0] LIN_BIAS = 27'd646;
   localparam logic [DIVIDEND_W-1:0] POW_SCALE = 27'd16000;
   localparam logic [DIVIDEND_W-1:0] POW_BIAS = 27'd3605007;
   localparam logic [Q16_W-1:0] SEARCH_HI = 17'd65537;

   // Division by 1292 and 1055 as a product with a rounded-up reciprocal.
   // The shift covers every dividend below 2**27 exactly.
   localparam int RECIP_W = 28;
   localparam int RECIP_SHIFT = 38;
   localparam int QUOT_PROD_W = DIVIDEND_W + RECIP_W;
   localparam logic [RECIP_W-1:0] LIN_RECIP = 28'd212753798;
   localparam logic [RECIP_W-1:0] POW_RECIP = 28'd260547780;

   typedef logic [COMP_W-1:0] comp_type;
   typedef logic [Q16_W-1:0] q16_type;

   typedef struct packed {
      logic     start;
      comp_type comp;
   } lin_req_type;

   typedef struct packed {
      logic    done;
      q16_type value;
   } lin_rsp_type;

   typedef enum logic [2:0] {
      LIN_IDLE,
      LIN_DIV,
      LIN_SQUARE,
      LIN_SEARCH,
      LIN_POWER,
      LIN_COMPARE,
      LIN_FINISH,
      LIN_DONE
   } lin_state_type;

   typedef enum logic [2:0] {
      T_IDLE,
      T_LIN_GO,
      T_LIN_WAIT,
      T_LUM,
      T_TEST,
      T_DECIDE,
      T_DONE
   } top_state_type;

   // Saturate a component to 1.0.
   function automatic comp_type sat_one(input comp_type c);
      return (c > ONE_C) ? ONE_C : c;
   endfunction

   // Luminance weight of one component.
   function automatic logic [15:0] lum_weight(input logic [1:0] sel);
      logic [15:0] w;
      case (sel)
         2'd0: w = W_RED;
         2'd1: w = W_GREEN;
         default: w = W_BLUE;
      endcase
      return w;
   endfunction

endpackage

// ===== rtl/core/tce_channels.sv =====
interface tce_req_if;
   logic               valid;
   logic               ready;
   tce_pkg::comp_type  text_red;
   tce_pkg::comp_type  text_green;
   tce_pkg::comp_type  text_blue;
   tce_pkg::comp_type  back_red;
   tce_pkg::comp_type  back_green;
   tce_pkg::comp_type  back_blue;

   modport source (output valid, text_red, text_green, text_blue,
                   back_red, back_green, back_blue, input ready);
   modport sink (input valid, text_red, text_green, text_blue,
                 back_red, back_green, back_blue, output ready);
endinterface

interface tce_rsp_if;
   logic               valid;
   logic               ready;
   tce_pkg::comp_type  out_red;
   tce_pkg::comp_type  out_green;
   tce_pkg::comp_type  out_blue;

   modport source (output valid, out_red, out_green, out_blue, input ready);
   modport sink (input valid, out_red, out_green, out_blue, output ready);
endinterface

// ===== rtl/core/tce_lin_unit.sv =====
module tce_lin_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  tce_pkg::lin_req_type lin_req,
   output tce_pkg::lin_rsp_type lin_rsp
);

   tce_pkg::lin_state_type state_ff, state_in;

   logic [tce_pkg::DIVIDEND_W-1:0] dividend_ff, dividend_in;
   logic                           linear_ff, linear_in;
   logic [1:0]                     k_ff, k_in;
   tce_pkg::q16_type               quo_ff, quo_in;
   tce_pkg::q16_type               q_ff, q_in;
   tce_pkg::q16_type               lo_ff, lo_in;
   tce_pkg::q16_type               hi_ff, hi_in;
   tce_pkg::q16_type               mid_ff, mid_in;
   tce_pkg::q16_type               p_ff, p_in;
   tce_pkg::q16_type               value_ff, value_in;

   logic [tce_pkg::DIVIDEND_W-1:0]  dividend;
   logic [tce_pkg::RECIP_W-1:0]     recip;
   logic [tce_pkg::QUOT_PROD_W-1:0] quot_prod;
   tce_pkg::q16_type                quotient;
   tce_pkg::q16_type                mul_a, mul_b;
   logic [tce_pkg::PROD_W-1:0]      prod;
   logic [34:0]                     rnd;
   tce_pkg::q16_type                span;
   logic [17:0]                     mid_sum;

   // Dividend of the curve segment that the component falls in.
   always_comb begin
      if (lin_req.comp <= tce_pkg::LIN_KNEE) begin
         dividend = tce_pkg::DIVIDEND_W'(lin_req.comp) * tce_pkg::LIN_SCALE
                    + tce_pkg::LIN_BIAS;
      end else begin
         dividend = tce_pkg::DIVIDEND_W'(lin_req.comp) * tce_pkg::POW_SCALE
                    + tce_pkg::POW_BIAS;
      end
   end

   // Division by the segment's constant through its reciprocal.
   assign recip = linear_ff ? tce_pkg::LIN_RECIP : tce_pkg::POW_RECIP;
   assign quot_prod = tce_pkg::QUOT_PROD_W'(dividend_ff) * tce_pkg::QUOT_PROD_W'(recip);
   assign quotient = quot_prod[tce_pkg::QUOT_PROD_W-1:tce_pkg::RECIP_SHIFT];

   // Shared multiplier, operands chosen by the sequencer.
   always_comb begin
      case (state_ff)
         tce_pkg::LIN_SQUARE: begin
            mul_a = quo_ff;
            mul_b = quo_ff;
         end
         tce_pkg::LIN_FINISH: begin
            mul_a = q_ff;
            mul_b = lo_ff;
         end
         default: begin
            mul_a = p_ff;
            mul_b = mid_ff;
         end
      endcase
   end

   assign prod = mul_a * mul_b;
   assign rnd = {1'b0, prod} + tce_pkg::ROUND_Q16;
   assign span = hi_ff - lo_ff;
   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tce_pkg::LIN_IDLE: begin
            if (lin_req.start) state_in = tce_pkg::LIN_DIV;
         end
         tce_pkg::LIN_DIV: begin
            state_in = linear_ff ? tce_pkg::LIN_DONE : tce_pkg::LIN_SQUARE;
         end
         tce_pkg::LIN_SQUARE: state_in = tce_pkg::LIN_SEARCH;
         tce_pkg::LIN_SEARCH: begin
            state_in = (span > 17'd1) ? tce_pkg::LIN_POWER : tce_pkg::LIN_FINISH;
         end
         tce_pkg::LIN_POWER: begin
            if (k_ff == 2'd3) state_in = tce_pkg::LIN_COMPARE;
         end
         tce_pkg::LIN_COMPARE: state_in = tce_pkg::LIN_SEARCH;
         tce_pkg::LIN_FINISH: state_in = tce_pkg::LIN_DONE;
         tce_pkg::LIN_DONE: state_in = tce_pkg::LIN_IDLE;
         default: state_in = tce_pkg::LIN_IDLE;
      endcase
   end

   // Datapath updates and outputs.
   always_comb begin
      dividend_in = dividend_ff;
      linear_in = linear_ff;
      k_in = k_ff;
      quo_in = quo_ff;
      q_in = q_ff;
      lo_in = lo_ff;
      hi_in = hi_ff;
      mid_in = mid_ff;
      p_in = p_ff;
      value_in = value_ff;
      lin_rsp.done = 1'b0;
      lin_rsp.value = value_ff;
      case (state_ff)
         tce_pkg::LIN_IDLE: begin
            dividend_in = dividend;
            linear_in = lin_req.comp <= tce_pkg::LIN_KNEE;
         end
         tce_pkg::LIN_DIV: begin
            quo_in = quotient;
            if (linear_ff) value_in = quotient;
         end
         tce_pkg::LIN_SQUARE: begin
            q_in = rnd[32:16];
            lo_in = '0;
            hi_in = tce_pkg::SEARCH_HI;
         end
         tce_pkg::LIN_SEARCH: begin
            mid_in = mid_sum[17:1];
            p_in = mid_sum[17:1];
            k_in = '0;
         end
         tce_pkg::LIN_POWER: begin
            p_in = prod[32:16];
            k_in = k_ff + 2'd1;
         end
         tce_pkg::LIN_COMPARE: begin
            if (p_ff <= q_ff) lo_in = mid_ff;
            else hi_in = mid_ff;
         end
         tce_pkg::LIN_FINISH: begin
            value_in = rnd[32:16];
         end
         tce_pkg::LIN_DONE: begin
            lin_rsp.done = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tce_pkg::LIN_IDLE;
      end else begin
         state_ff <= state_in;
      end
      dividend_ff <= dividend_in;
      linear_ff <= linear_in;
      k_ff <= k_in;
      quo_ff <= quo_in;
      q_ff <= q_in;
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      mid_ff <= mid_in;
      p_ff <= p_in;
      value_ff <= value_in;
   end

endmodule

// ===== rtl/core/text_contrast_enforcer_unit.sv =====
// Channel  Direction  Fields
// req      in         text_red, text_green, text_blue, back_red, back_green, back_blue
// rsp      out        out_red, out_green, out_blue
// csr      in         required contrast ratio (write enable and data)
//
// A component takes longer on the power segment than on the linear one,
// bound by the binary search on the linearizer's multiplier.
// A contrast test is three components plus the luminance, test and decide steps.
// A request takes one background pass plus up to 20 text tests.
// Reset is synchronous; the block is ready again once its result is loaded.
// A stalled result is held in the output register while the next request runs.
module text_contrast_enforcer_unit (
   input  logic               clock,
   input  logic               reset,
   tce_req_if.sink            req_chan,
   tce_rsp_if.source          rsp_chan,
   input  logic               csr_write_enable,
   input  tce_pkg::comp_type  csr_write_data
);

   tce_pkg::top_state_type state_ff, state_in;

   tce_pkg::comp_type                txt_ff[3];
   tce_pkg::comp_type                txt_in[3];
   tce_pkg::comp_type                back_ff[3];
   tce_pkg::comp_type                back_in[3];
   tce_pkg::comp_type                ratio_floor_ff;
   logic                             phase_back_ff, phase_back_in;
   logic [1:0]                       sel_ff, sel_in;
   logic [tce_pkg::ACC_W-1:0]        acc_ff, acc_in;
   tce_pkg::q16_type                 back_lum_ff, back_lum_in;
   tce_pkg::q16_type                 text_lum_ff, text_lum_in;
   logic                             lighten_ff, lighten_in;
   logic [tce_pkg::STEP_CNT_W-1:0]   step_ff, step_in;
   logic [29:0]                      rhs_ff, rhs_in;
   logic [24:0]                      lhs_ff, lhs_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   tce_pkg::comp_type                out_ff[3];
   tce_pkg::comp_type                out_in[3];

   tce_pkg::lin_req_type             lin_req;
   tce_pkg::lin_rsp_type             lin_rsp;

   tce_pkg::q16_type                 mul_a, mul_b;
   logic [tce_pkg::PROD_W-1:0]       prod;
   logic [33:0]                      lum_rnd;
   tce_pkg::q16_type                 lum_hi, lum_lo;
   logic                             req_fire;
   logic                             out_free;
   logic                             passed;
   logic [tce_pkg::STEP_CNT_W-1:0]   step_next;
   logic [tce_pkg::COMP_W:0]         up_sum[3];

   tce_lin_unit u_lin (
      .clock   (clock),
      .reset   (reset),
      .lin_req (lin_req),
      .lin_rsp (lin_rsp)
   );

   assign req_chan.ready = (state_ff == tce_pkg::T_IDLE);
   assign req_fire = req_chan.valid && req_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.out_red = out_ff[0];
   assign rsp_chan.out_green = out_ff[1];
   assign rsp_chan.out_blue = out_ff[2];

   // Component handed to the linearizer.
   assign lin_req.start = (state_ff == tce_pkg::T_LIN_GO);
   assign lin_req.comp = phase_back_ff ? back_ff[sel_ff] : txt_ff[sel_ff];

   // Shared multiplier: weighted sum, then the ratio product.
   assign lum_hi = (text_lum_ff > back_lum_ff) ? text_lum_ff : back_lum_ff;
   assign lum_lo = (text_lum_ff > back_lum_ff) ? back_lum_ff : text_lum_ff;
   always_comb begin
      if (state_ff == tce_pkg::T_TEST) begin
         mul_a = {4'b0, ratio_floor_ff};
         mul_b = lum_lo + tce_pkg::OFFSET_Q16;
      end else begin
         mul_a = {1'b0, tce_pkg::lum_weight(sel_ff)};
         mul_b = lin_rsp.value;
      end
   end
   assign prod = mul_a * mul_b;
   assign lum_rnd = {1'b0, acc_ff} + 34'd32768;
   assign passed = {5'b0, lhs_ff} >= rhs_ff;
   assign step_next = step_ff + 1'b1;

   for (genvar i = 0; i < 3; i++) begin : g_up
      assign up_sum[i] = {1'b0, txt_ff[i]} + {1'b0, tce_pkg::STEP_C};
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tce_pkg::T_IDLE: begin
            if (req_fire) state_in = tce_pkg::T_LIN_GO;
         end
         tce_pkg::T_LIN_GO: state_in = tce_pkg::T_LIN_WAIT;
         tce_pkg::T_LIN_WAIT: begin
            if (lin_rsp.done) begin
               state_in = (sel_ff == 2'd2) ? tce_pkg::T_LUM : tce_pkg::T_LIN_GO;
            end
         end
         tce_pkg::T_LUM: begin
            state_in = phase_back_ff ? tce_pkg::T_LIN_GO : tce_pkg::T_TEST;
         end
         tce_pkg::T_TEST: state_in = tce_pkg::T_DECIDE;
         tce_pkg::T_DECIDE: begin
            if (passed || step_next == tce_pkg::STEP_CNT_W'(tce_pkg::MAX_STEPS)) begin
               state_in = tce_pkg::T_DONE;
            end else begin
               state_in = tce_pkg::T_LIN_GO;
            end
         end
         tce_pkg::T_DONE: begin
            if (out_free) state_in = tce_pkg::T_IDLE;
         end
         default: state_in = tce_pkg::T_IDLE;
      endcase
   end

   // Datapath updates.
   always_comb begin
      txt_in = txt_ff;
      back_in = back_ff;
      phase_back_in = phase_back_ff;
      sel_in = sel_ff;
      acc_in = acc_ff;
      back_lum_in = back_lum_ff;
      text_lum_in = text_lum_ff;
      lighten_in = lighten_ff;
      step_in = step_ff;
      rhs_in = rhs_ff;
      lhs_in = lhs_ff;
      out_in = out_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      case (state_ff)
         tce_pkg::T_IDLE: begin
            txt_in[0] = tce_pkg::sat_one(req_chan.text_red);
            txt_in[1] = tce_pkg::sat_one(req_chan.text_green);
            txt_in[2] = tce_pkg::sat_one(req_chan.text_blue);
            back_in[0] = tce_pkg::sat_one(req_chan.back_red);
            back_in[1] = tce_pkg::sat_one(req_chan.back_green);
            back_in[2] = tce_pkg::sat_one(req_chan.back_blue);
            phase_back_in = 1'b1;
            sel_in = '0;
            acc_in = '0;
            step_in = '0;
         end
         tce_pkg::T_LIN_WAIT: begin
            if (lin_rsp.done) begin
               acc_in = acc_ff + prod[tce_pkg::ACC_W-1:0];
               if (sel_ff != 2'd2) sel_in = sel_ff + 2'd1;
            end
         end
         tce_pkg::T_LUM: begin
            if (phase_back_ff) begin
               back_lum_in = lum_rnd[32:16];
               lighten_in = lum_rnd[32:16] < tce_pkg::HALF_Q16;
               phase_back_in = 1'b0;
               sel_in = '0;
               acc_in = '0;
            end else begin
               text_lum_in = lum_rnd[32:16];
            end
         end
         tce_pkg::T_TEST: begin
            rhs_in = prod[29:0];
            lhs_in = {lum_hi + tce_pkg::OFFSET_Q16, 8'b0};
         end
         tce_pkg::T_DECIDE: begin
            if (!passed) begin
               // Move all three text components one step, clamped to 0..1.0.
               for (int i = 0; i < 3; i++) begin
                  if (lighten_ff) begin
                     txt_in[i] = (up_sum[i] > {1'b0, tce_pkg::ONE_C}) ?
                                 tce_pkg::ONE_C : up_sum[i][tce_pkg::COMP_W-1:0];
                  end else begin
                     txt_in[i] = (txt_ff[i] < tce_pkg::STEP_C) ?
                                 '0 : txt_ff[i] - tce_pkg::STEP_C;
                  end
               end
               step_in = step_next;
               sel_in = '0;
               acc_in = '0;
            end
         end
         tce_pkg::T_DONE: begin
            if (out_free) begin
               out_in = txt_ff;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tce_pkg::T_IDLE;
         rsp_valid_ff <= 1'b0;
         ratio_floor_ff <= tce_pkg::RESET_RATIO_FLOOR;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) ratio_floor_ff <= csr_write_data;
      end
      txt_ff <= txt_in;
      back_ff <= back_in;
      phase_back_ff <= phase_back_in;
      sel_ff <= sel_in;
      acc_ff <= acc_in;
      back_lum_ff <= back_lum_in;
      text_lum_ff <= text_lum_in;
      lighten_ff <= lighten_in;
      step_ff <= step_in;
      rhs_ff <= rhs_in;
      lhs_ff <= lhs_in;
      out_ff <= out_in;
   end

`ifndef SYNTHESIS
   // The move counter never passes its bound while a request is in work.
   assert property (@(posedge clock) disable iff (reset)
      state_ff != tce_pkg::T_IDLE |-> step_ff <= tce_pkg::STEP_CNT_W'(tce_pkg::MAX_STEPS))
      else $error("move counter beyond its bound");

   // The linearizer only reports back while the sequencer waits for it.
   assert property (@(posedge clock) disable iff (reset)
      lin_rsp.done |-> state_ff == tce_pkg::T_LIN_WAIT)
      else $error("linearizer result outside of a wait");

   // A pending result never holds a component above 1.0.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (out_ff[0] <= tce_pkg::ONE_C) && (out_ff[1] <= tce_pkg::ONE_C)
                       && (out_ff[2] <= tce_pkg::ONE_C))
      else $error("result component above 1.0");

   // An accepted request starts with the background color.
   assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == tce_pkg::T_LIN_GO && phase_back_ff)
      else $error("request did not start on the background");
`endif

endmodule

// ===== test/text_contrast_enforcer_unit_tb.sv =====
`timescale 1ns / 1ps

module text_contrast_enforcer_unit_tb;

   typedef struct {
      tce_pkg::comp_type red;
      tce_pkg::comp_type green;
      tce_pkg::comp_type blue;
   } rgb_type;

   logic              clock;
   logic              reset;
   logic              csr_write_enable;
   tce_pkg::comp_type csr_write_data;

   tce_req_if req_chan ();
   tce_rsp_if rsp_chan ();

   text_contrast_enforcer_unit uut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // Copy of the ratio register and the colors still owed by the block.
   tce_pkg::comp_type ratio_setting;
   rgb_type  adjusted_colors[$];
   int       error_count;
   int       send_idle_pct;
   int       recv_idle_pct;
   int       hold_count;

   // Clock: 20 ns period.
   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // sRGB component to linear light in Q16.
   function automatic longint unsigned linear_light(input tce_pkg::comp_type c);
      longint unsigned s, v, q, lo, hi, mid, p;
      s = ((c > tce_pkg::ONE_C) ? 4096 : c) << 4;
      if (s * 100000 <= 64'd4045 * 65536)
         return (s * 100 + 646) / 1292;
      v = (s * 1000 + 64'd55 * 65536 + 527) / 1055;
      q = (v * v + 32768) >> 16;
      lo = 0;
      hi = 65537;
      // Fifth root of q by bisection, with truncating products.
      while (hi - lo > 1) begin
         mid = (lo + hi) >> 1;
         p = mid;
         for (int k = 0; k < 4; k++)
            p = (p * mid) >> 16;
         if (p <= q)
            lo = mid;
         else
            hi = mid;
      end
      return (q * lo + 32768) >> 16;
   endfunction

   function automatic longint unsigned luminance_of(input rgb_type c);
      return (64'd13933 * linear_light(c.red) + 64'd46871 * linear_light(c.green)
              + 64'd4732 * linear_light(c.blue) + 32768) >> 16;
   endfunction

   // Moves the text color until the contrast test passes or steps run out.
   function automatic rgb_type enforce_contrast(input rgb_type txt, input rgb_type back);
      longint unsigned back_lum, text_lum, hi, lo;
      logic lighten;
      tce_pkg::comp_type comps[3];
      back.red = (back.red > tce_pkg::ONE_C) ? tce_pkg::ONE_C : back.red;
      back.green = (back.green > tce_pkg::ONE_C) ? tce_pkg::ONE_C : back.green;
      back.blue = (back.blue > tce_pkg::ONE_C) ? tce_pkg::ONE_C : back.blue;
      comps[0] = (txt.red > tce_pkg::ONE_C) ? tce_pkg::ONE_C : txt.red;
      comps[1] = (txt.green > tce_pkg::ONE_C) ? tce_pkg::ONE_C : txt.green;
      comps[2] = (txt.blue > tce_pkg::ONE_C) ? tce_pkg::ONE_C : txt.blue;
      back_lum = luminance_of(back);
      lighten = back_lum < 32768;
      for (int i = 0; i < tce_pkg::MAX_STEPS; i++) begin
         txt.red = comps[0];
         txt.green = comps[1];
         txt.blue = comps[2];
         text_lum = luminance_of(txt);
         hi = (text_lum > back_lum) ? text_lum : back_lum;
         lo = (text_lum > back_lum) ? back_lum : text_lum;
         if ((hi + 3277) * 256 >= ratio_setting * (lo + 3277))
            break;
         for (int k = 0; k < 3; k++) begin
            if (lighten)
               comps[k] = (comps[k] + tce_pkg::STEP_C > tce_pkg::ONE_C) ?
                          tce_pkg::ONE_C : comps[k] + tce_pkg::STEP_C;
            else
               comps[k] = (comps[k] < tce_pkg::STEP_C) ?
                          13'd0 : comps[k] - tce_pkg::STEP_C;
         end
      end
      txt.red = comps[0];
      txt.green = comps[1];
      txt.blue = comps[2];
      return txt;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("ERROR at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      error_count++;
   endtask

   // Result checker: each accepted result against the oldest expectation.
   always @(posedge clock) begin
      rgb_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (adjusted_colors.size() == 0) begin
            report_mismatch("unexpected result, red", rsp_chan.out_red, -1);
         end else begin
            want = adjusted_colors.pop_front();
            if (rsp_chan.out_red !== want.red)
               report_mismatch("out_red", rsp_chan.out_red, want.red);
            if (rsp_chan.out_green !== want.green)
               report_mismatch("out_green", rsp_chan.out_green, want.green);
            if (rsp_chan.out_blue !== want.blue)
               report_mismatch("out_blue", rsp_chan.out_blue, want.blue);
         end
      end
   end

   // Receiver: random stalls, plus a long hold-off when one is requested.
   always @(negedge clock) begin
      if (hold_count > 0) begin
         hold_count = hold_count - 1;
         rsp_chan.ready = 1'b0;
      end else begin
         rsp_chan.ready = ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Sends one request and records the color it must produce.
   task automatic send_colors(input tce_pkg::comp_type tr, input tce_pkg::comp_type tg,
                              input tce_pkg::comp_type tb, input tce_pkg::comp_type br,
                              input tce_pkg::comp_type bg, input tce_pkg::comp_type bb);
      rgb_type txt, back;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid = 1'b0;
         @(negedge clock);
      end
      req_chan.valid = 1'b1;
      req_chan.text_red = tr;
      req_chan.text_green = tg;
      req_chan.text_blue = tb;
      req_chan.back_red = br;
      req_chan.back_green = bg;
      req_chan.back_blue = bb;
      do
         @(posedge clock);
      while (!req_chan.ready);
      txt = '{tr, tg, tb};
      back = '{br, bg, bb};
      adjusted_colors.push_back(enforce_contrast(txt, back));
   endtask

   task automatic drain_results;
      @(negedge clock);
      req_chan.valid = 1'b0;
      wait (adjusted_colors.size() == 0);
      repeat (5) @(negedge clock);
   endtask

   // Register writes happen only with the block idle.
   task automatic write_ratio(input tce_pkg::comp_type value);
      drain_results();
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_write_data = value;
      @(negedge clock);
      csr_write_enable = 1'b0;
      ratio_setting = value;
   endtask

   function automatic tce_pkg::comp_type random_comp;
      int pick;
      pick = $urandom_range(99);
      if (pick < 6)
         return 13'd0;
      else if (pick < 12)
         return tce_pkg::ONE_C;
      else if (pick < 17)
         return tce_pkg::comp_type'($urandom_range(8191, 4097));
      else if (pick < 25)
         return tce_pkg::comp_type'($urandom_range(200, 130));
      return tce_pkg::comp_type'($urandom_range(4096));
   endfunction

   // Extremes of the fields, the knee of the curve and saturation.
   task automatic test_extremes;
      send_colors(0, 0, 0, 0, 0, 0);
      send_colors(4096, 4096, 4096, 4096, 4096, 4096);
      send_colors(0, 0, 0, 4096, 4096, 4096);
      send_colors(4096, 4096, 4096, 0, 0, 0);
      send_colors(165, 165, 165, 166, 166, 166);
      send_colors(8191, 8191, 8191, 8191, 8191, 8191);
      send_colors(8191, 0, 4097, 0, 8191, 4097);
      send_colors(2048, 2048, 2048, 2048, 2048, 2048);
      send_colors(4000, 100, 3000, 2900, 2900, 2900);
      send_colors(1, 4095, 2, 4095, 1, 4094);
      drain_results();
   endtask

   // Ratio extremes: always passing, unreachable and the register's full width.
   task automatic test_ratio_limits;
      tce_pkg::comp_type settings[5] = '{13'd0, 13'd256, 13'd5376, 13'd8191, 13'd255};
      foreach (settings[i]) begin
         write_ratio(settings[i]);
         send_colors(0, 0, 0, 0, 0, 0);
         send_colors(4096, 4096, 4096, 4096, 4096, 4096);
         send_colors(1000, 2000, 3000, 3000, 2000, 1000);
      end
      write_ratio(tce_pkg::RESET_RATIO_FLOOR);
   endtask

   // Long output stall while requests keep coming, so the input backs up.
   task automatic test_backpressure;
      @(negedge clock);
      hold_count = 30000;
      for (int i = 0; i < 5; i++)
         send_colors(4096, 4096, 4096, 4096, 4096, 4096);
      drain_results();
   endtask

   task automatic test_random(input int count, input int s_idle, input int r_idle,
                              input tce_pkg::comp_type ratio);
      write_ratio(ratio);
      send_idle_pct = s_idle;
      recv_idle_pct = r_idle;
      for (int i = 0; i < count; i++)
         send_colors(random_comp(), random_comp(), random_comp(),
                     random_comp(), random_comp(), random_comp());
      drain_results();
   endtask

   initial begin
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      req_chan.valid = 1'b0;
      req_chan.text_red = '0;
      req_chan.text_green = '0;
      req_chan.text_blue = '0;
      req_chan.back_red = '0;
      req_chan.back_green = '0;
      req_chan.back_blue = '0;
      rsp_chan.ready = 1'b0;
      ratio_setting = tce_pkg::RESET_RATIO_FLOOR;
      error_count = 0;
      hold_count = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_extremes();
      test_ratio_limits();
      test_backpressure();
      test_random(530, 28, 84, 13'd1152);
      test_random(530, 84, 28, 13'd256);
      test_random(260, 0, 0, 13'd5376);
      test_random(270, 0, 0, 13'd1792);

      repeat (200) @(posedge clock);
      if (error_count == 0)
         $display("text_contrast_enforcer_unit_tb OK");
      else
         $display("text_contrast_enforcer_unit_tb NOT OK");
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #(64'd2_000_000_000);
      $display("text_contrast_enforcer_unit_tb NOT OK");
      $finish;
   end

endmodule
